/* src/assert_macros.svh */
// assertion macros for the rtl of the schnorr engine, used by its top level
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock, masked while reset is low
`define SIE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in one cycle implies another in the next cycle
`define SIE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/sie_pkg.sv */
// shared constants and types of the schnorr identification engine
// no dependencies
package sie_pkg;

	// widths fixed by the interface
	localparam int MOD_WIDTH_DEF = 16;
	localparam int FIELD_W       = 16;
	localparam int SECRET_W      = 31;
	localparam int OP_W          = 2;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	// register reset values
	localparam logic [FIELD_W-1:0] P_RESET = 16'd3329;
	localparam logic [FIELD_W-1:0] G_RESET = 16'd2;

	// operation codes
	localparam logic [OP_W-1:0] OP_KEYGEN = 2'd0;
	localparam logic [OP_W-1:0] OP_PROVE  = 2'd1;
	localparam logic [OP_W-1:0] OP_VERIFY = 2'd2;

	// register select, word address bit 2
	localparam logic REG_PRIME = 1'b0;
	localparam logic REG_GEN   = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_SECRET,
		ST_RED_BASE,
		ST_SQUARE,
		ST_MULT,
		ST_POW_END,
		ST_RED_X,
		ST_RED_R,
		ST_MUL_CX,
		ST_ADD_R,
		ST_RED_T,
		ST_MUL_T,
		ST_DONE
	} state_t;

endpackage

/* src/sie_modmul.sv */
// bit-serial modular multiplier: product = a * b mod m, b shifted out lsb first
// depends on sie_pkg for default widths
module sie_modmul import sie_pkg::*; #(
	parameter int MOD_WIDTH    = MOD_WIDTH_DEF,
	parameter int STREAM_WIDTH = SECRET_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [MOD_WIDTH-1:0]    mult_a,
	input  logic [STREAM_WIDTH-1:0] mult_b,
	input  logic [MOD_WIDTH-1:0]    modulus,
	output logic                    busy,
	output logic                    done,
	output logic [MOD_WIDTH-1:0]    product
);

	logic                    busy_q;
	logic [MOD_WIDTH-1:0]    acc_q;
	logic [MOD_WIDTH-1:0]    dbl_q;
	logic [MOD_WIDTH-1:0]    mod_q;
	logic [STREAM_WIDTH-1:0] sh_q;

	logic [MOD_WIDTH:0]   sum_add;
	logic [MOD_WIDTH:0]   sum_dbl;
	logic [MOD_WIDTH:0]   mod_ext;
	logic [MOD_WIDTH-1:0] acc_nxt;
	logic [MOD_WIDTH-1:0] dbl_nxt;

	// accumulate a*2^i and double it, each with one conditional subtract
	always_comb begin
		mod_ext = {1'b0, mod_q};
		sum_add = {1'b0, acc_q} + {1'b0, dbl_q};
		sum_dbl = {dbl_q, 1'b0};
		if (sum_add >= mod_ext) begin
			acc_nxt = MOD_WIDTH'(sum_add - mod_ext);
		end else begin
			acc_nxt = sum_add[MOD_WIDTH-1:0];
		end
		if (sum_dbl >= mod_ext) begin
			dbl_nxt = MOD_WIDTH'(sum_dbl - mod_ext);
		end else begin
			dbl_nxt = sum_dbl[MOD_WIDTH-1:0];
		end
	end

	// finished once the multiplier bits run out
	assign done    = busy_q && (sh_q == '0);
	assign busy    = busy_q;
	assign product = acc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			dbl_q <= mult_a;
			sh_q  <= mult_b;
			mod_q <= modulus;
		end else if (busy_q && !done) begin
			if (sh_q[0]) begin
				acc_q <= acc_nxt;
			end
			dbl_q <= dbl_nxt;
			sh_q  <= sh_q >> 1;
		end
	end

endmodule

/* src/schnorr_identification_engine.sv */
// top level of the schnorr identification engine: sequencer, operand store, apb registers
// depends on sie_pkg, sie_modmul and assert_macros.svh
//
// channel   direction  handshake
// request   in         taken when start is high and busy is low
// result    out        done high for one cycle, fields valid with it
// config    in         apb write at psel & penable & pwrite & pready
//
// one shared bit-serial multiplier does every multiply and modular reduction; a
// multiply is launched, shifts through the significant bits of its serial operand
// and then finishes; an exponentiation costs up to two multiplies per exponent bit
// reset leaves the block idle with modulus 3329 and generator 2
// results cannot be stalled: done is raised once and the block returns to idle
`include "assert_macros.svh"

module schnorr_identification_engine import sie_pkg::*; #(
	parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [SECRET_W-1:0] secret,
	input  logic [FIELD_W-1:0]  prove_key,
	input  logic [FIELD_W-1:0]  random_exponent,
	input  logic [FIELD_W-1:0]  challenge,
	input  logic [FIELD_W-1:0]  commitment,
	input  logic [FIELD_W-1:0]  response,
	input  logic [FIELD_W-1:0]  verify_key,
	// result
	output logic                done,
	output logic [FIELD_W-1:0]  key_or_commitment,
	output logic [FIELD_W-1:0]  private_key_out,
	output logic [FIELD_W-1:0]  response_out,
	output logic                accepted,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int MW  = MOD_WIDTH;
	localparam int SW  = (MW > SECRET_W) ? MW : SECRET_W;
	localparam int EW  = (MW > FIELD_W) ? MW : FIELD_W;
	localparam int ECW = $clog2(EW + 1);

	// configuration registers
	logic [MW-1:0] p_q;
	logic [MW-1:0] g_q;

	// sequencer
	state_t state_q;
	state_t state_nxt;
	logic   issued_q;

	// latched request
	logic [OP_W-1:0]     op_q;
	logic [SECRET_W-1:0] secret_q;
	logic [FIELD_W-1:0]  x_q;
	logic [FIELD_W-1:0]  r_q;
	logic [FIELD_W-1:0]  c_q;
	logic [FIELD_W-1:0]  t_q;
	logic [FIELD_W-1:0]  s_q;
	logic [FIELD_W-1:0]  y_q;

	// working registers
	logic [MW-1:0]  m_q;
	logic [MW-1:0]  q_q;
	logic [MW-1:0]  one_m_q;
	logic [MW-1:0]  one_q_q;
	logic           phase_q;
	logic [MW-1:0]  base_q;
	logic [MW-1:0]  pacc_q;
	logic [MW-1:0]  tmp_q;
	logic [MW-1:0]  left_q;
	logic [EW-1:0]  exp_q;
	logic [ECW-1:0] ecnt_q;

	// results
	logic [MW-1:0] kc_q;
	logic [MW-1:0] priv_q;
	logic [MW-1:0] resp_q;
	logic          ok_q;

	// multiplier hookup
	logic          u_go;
	logic [MW-1:0] u_a;
	logic [SW-1:0] u_b;
	logic [MW-1:0] u_m;
	logic          u_busy;
	logic          u_done;
	logic [MW-1:0] u_prod;

	// derived values
	logic          req_take;
	logic          cfg_wr;
	logic [MW-1:0] m_eff;
	logic [MW-1:0] q_eff;
	logic [EW-1:0] exp_src;
	logic          exp_last;
	logic [MW:0]   add_sum;
	logic [MW-1:0] add_red;

	assign req_take = start && !busy;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= MW'(P_RESET);
			g_q <= MW'(G_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PRIME: p_q <= MW'(pwdata[FIELD_W-1:0]);
				REG_GEN:   g_q <= MW'(pwdata[FIELD_W-1:0]);
				default:   p_q <= p_q;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[2])
			REG_GEN: prdata = DATA_W'(g_q);
			default: prdata = DATA_W'(p_q);
		endcase
	end

	// moduli: zero modulus acts as one, group order is p-1, or zero below two
	always_comb begin
		m_eff = (p_q == '0) ? MW'(1) : p_q;
		q_eff = (p_q >= MW'(2)) ? MW'(p_q - MW'(1)) : '0;
	end

	// exponent for the current power
	always_comb begin
		unique case (op_q)
			OP_KEYGEN: exp_src = EW'(priv_q);
			OP_PROVE:  exp_src = EW'(r_q);
			OP_VERIFY: exp_src = phase_q ? EW'(c_q) : EW'(s_q);
			default:   exp_src = '0;
		endcase
	end

	assign exp_last = (ecnt_q == ECW'(1));

	// final response add modulo the group order
	always_comb begin
		add_sum = {1'b0, pacc_q} + {1'b0, base_q};
		if (add_sum >= {1'b0, q_q}) begin
			add_red = MW'(add_sum - {1'b0, q_q});
		end else begin
			add_red = add_sum[MW-1:0];
		end
	end

	// shared multiplier
	sie_modmul #(
		.MOD_WIDTH    (MW),
		.STREAM_WIDTH (SW)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (u_go),
		.mult_a  (u_a),
		.mult_b  (u_b),
		.modulus (u_m),
		.busy    (u_busy),
		.done    (u_done),
		.product (u_prod)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					unique case (operation)
						OP_KEYGEN:            state_nxt = ST_RED_SECRET;
						OP_PROVE, OP_VERIFY:  state_nxt = ST_RED_BASE;
						default:              state_nxt = ST_DONE;
					endcase
				end
			end
			ST_RED_SECRET: if (u_done) state_nxt = ST_RED_BASE;
			ST_RED_BASE:   if (u_done) state_nxt = ST_SQUARE;
			ST_SQUARE: begin
				if (u_done) begin
					priority if (exp_q[EW-1]) state_nxt = ST_MULT;
					else if (exp_last)        state_nxt = ST_POW_END;
					else                      state_nxt = ST_SQUARE;
				end
			end
			ST_MULT: begin
				if (u_done) begin
					state_nxt = exp_last ? ST_POW_END : ST_SQUARE;
				end
			end
			ST_POW_END: begin
				unique case (op_q)
					OP_KEYGEN: state_nxt = ST_DONE;
					OP_PROVE:  state_nxt = (q_q == '0) ? ST_DONE : ST_RED_X;
					OP_VERIFY: state_nxt = phase_q ? ST_RED_T : ST_RED_BASE;
					default:   state_nxt = ST_DONE;
				endcase
			end
			ST_RED_X:  if (u_done) state_nxt = ST_RED_R;
			ST_RED_R:  if (u_done) state_nxt = ST_MUL_CX;
			ST_MUL_CX: if (u_done) state_nxt = ST_ADD_R;
			ST_ADD_R:  state_nxt = ST_DONE;
			ST_RED_T:  if (u_done) state_nxt = ST_MUL_T;
			ST_MUL_T:  if (u_done) state_nxt = ST_DONE;
			ST_DONE:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs: multiplier operands per state
	always_comb begin
		u_go = 1'b0;
		u_a  = '0;
		u_b  = '0;
		u_m  = m_q;
		unique case (state_q)
			ST_RED_SECRET: begin
				u_go = !issued_q;
				u_a  = one_m_q;
				u_b  = SW'(secret_q);
			end
			ST_RED_BASE: begin
				u_go = !issued_q;
				u_a  = one_m_q;
				u_b  = phase_q ? SW'(y_q) : SW'(g_q);
			end
			ST_SQUARE: begin
				u_go = !issued_q;
				u_a  = pacc_q;
				u_b  = SW'(pacc_q);
			end
			ST_MULT: begin
				u_go = !issued_q;
				u_a  = pacc_q;
				u_b  = SW'(base_q);
			end
			ST_RED_X: begin
				u_go = !issued_q;
				u_a  = one_q_q;
				u_b  = SW'(x_q);
				u_m  = q_q;
			end
			ST_RED_R: begin
				u_go = !issued_q;
				u_a  = one_q_q;
				u_b  = SW'(r_q);
				u_m  = q_q;
			end
			ST_MUL_CX: begin
				u_go = !issued_q;
				u_a  = tmp_q;
				u_b  = SW'(c_q);
				u_m  = q_q;
			end
			ST_RED_T: begin
				u_go = !issued_q;
				u_a  = one_m_q;
				u_b  = SW'(t_q);
			end
			ST_MUL_T: begin
				u_go = !issued_q;
				u_a  = tmp_q;
				u_b  = SW'(pacc_q);
			end
			default: begin
				u_go = 1'b0;
			end
		endcase
	end

	// state and launch flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (u_done) begin
				issued_q <= 1'b0;
			end else if (u_go) begin
				issued_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					op_q     <= operation;
					secret_q <= secret;
					x_q      <= prove_key;
					r_q      <= random_exponent;
					c_q      <= challenge;
					t_q      <= commitment;
					s_q      <= response;
					y_q      <= verify_key;
					m_q      <= m_eff;
					q_q      <= q_eff;
					one_m_q  <= MW'(m_eff != MW'(1));
					one_q_q  <= MW'(q_eff != MW'(1));
					phase_q  <= 1'b0;
					kc_q     <= '0;
					priv_q   <= '0;
					resp_q   <= '0;
					ok_q     <= 1'b0;
				end
			end
			ST_RED_SECRET: if (u_done) priv_q <= u_prod;
			ST_RED_BASE: begin
				if (u_done) begin
					base_q <= u_prod;
					pacc_q <= one_m_q;
					exp_q  <= exp_src;
					ecnt_q <= ECW'(EW);
				end
			end
			ST_SQUARE: begin
				if (u_done) begin
					pacc_q <= u_prod;
					if (!exp_q[EW-1]) begin
						exp_q  <= {exp_q[EW-2:0], 1'b0};
						ecnt_q <= ecnt_q - ECW'(1);
					end
				end
			end
			ST_MULT: begin
				if (u_done) begin
					pacc_q <= u_prod;
					exp_q  <= {exp_q[EW-2:0], 1'b0};
					ecnt_q <= ecnt_q - ECW'(1);
				end
			end
			ST_POW_END: begin
				if (op_q == OP_VERIFY) begin
					// first power is g^s, kept for the final compare
					if (!phase_q) begin
						left_q <= pacc_q;
					end
					phase_q <= 1'b1;
				end else begin
					kc_q <= pacc_q;
				end
			end
			ST_RED_X:  if (u_done) tmp_q <= u_prod;
			ST_RED_R:  if (u_done) base_q <= u_prod;
			ST_MUL_CX: if (u_done) pacc_q <= u_prod;
			ST_ADD_R:  resp_q <= add_red;
			ST_RED_T:  if (u_done) tmp_q <= u_prod;
			ST_MUL_T:  if (u_done) ok_q <= (u_prod == left_q);
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	// result ports
	assign busy              = (state_q != ST_IDLE);
	assign done              = (state_q == ST_DONE);
	assign key_or_commitment = FIELD_W'(kc_q);
	assign private_key_out   = FIELD_W'(priv_q);
	assign response_out      = FIELD_W'(resp_q);
	assign accepted          = ok_q;

	// checks
	`SIE_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
	`SIE_ASSERT(a_go_free, u_go |-> !u_busy, "multiplier launched while busy")
	`SIE_ASSERT(a_accept_op, (done && accepted) |-> (op_q == OP_VERIFY), "accept outside verify")
	`SIE_ASSERT_NEXT(a_req_taken, req_take, busy, "request taken but engine idle")

endmodule

/* verif/schnorr_identification_engine_test.sv */
// testbench for the schnorr identification engine: directed and random requests
// with every result checked against an in-bench model of the modular arithmetic
// depends on sie_pkg and the engine rtl
module schnorr_identification_engine_test;
	import sie_pkg::*;

	localparam int CYCLE_LIMIT     = 6_000_000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int SETTLE_CYCLES   = 1300;
	localparam int IDLE_CYCLES     = 4;
	localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_PRIME = {REG_PRIME, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_GEN   = {REG_GEN, 2'b00};

	typedef struct {
		logic [OP_W-1:0]     operation;
		logic [SECRET_W-1:0] secret;
		logic [FIELD_W-1:0]  prove_key;
		logic [FIELD_W-1:0]  random_exponent;
		logic [FIELD_W-1:0]  challenge;
		logic [FIELD_W-1:0]  commitment;
		logic [FIELD_W-1:0]  response;
		logic [FIELD_W-1:0]  verify_key;
	} request_t;

	typedef struct {
		logic [FIELD_W-1:0] key_or_commitment;
		logic [FIELD_W-1:0] private_key_out;
		logic [FIELD_W-1:0] response_out;
		logic               accepted;
	} proof_result_t;

	logic                clk;
	logic                arst_n          = 1'b0;
	logic                start           = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     operation       = '0;
	logic [SECRET_W-1:0] secret          = '0;
	logic [FIELD_W-1:0]  prove_key       = '0;
	logic [FIELD_W-1:0]  random_exponent = '0;
	logic [FIELD_W-1:0]  challenge       = '0;
	logic [FIELD_W-1:0]  commitment      = '0;
	logic [FIELD_W-1:0]  response        = '0;
	logic [FIELD_W-1:0]  verify_key      = '0;
	logic                done;
	logic [FIELD_W-1:0]  key_or_commitment;
	logic [FIELD_W-1:0]  private_key_out;
	logic [FIELD_W-1:0]  response_out;
	logic                accepted;
	logic                psel            = 1'b0;
	logic                penable         = 1'b0;
	logic                pwrite          = 1'b0;
	logic [ADDR_W-1:0]   paddr           = '0;
	logic [DATA_W-1:0]   pwdata          = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// mirror of the modulus and generator registers
	logic [FIELD_W-1:0] mirror_prime = P_RESET;
	logic [FIELD_W-1:0] mirror_gen   = G_RESET;

	proof_result_t pending_results[$];
	int            error_count  = 0;
	int            results_seen = 0;
	int            cycle_count  = 0;
	bit            idle_on      = 1'b1;

	schnorr_identification_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.secret(secret),
		.prove_key(prove_key),
		.random_exponent(random_exponent),
		.challenge(challenge),
		.commitment(commitment),
		.response(response),
		.verify_key(verify_key),
		.done(done),
		.key_or_commitment(key_or_commitment),
		.private_key_out(private_key_out),
		.response_out(response_out),
		.accepted(accepted),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// a zero modulus behaves as one
	function automatic longint unsigned effective_modulus();
		return (mirror_prime == '0) ? 64'd1 : 64'(mirror_prime);
	endfunction

	// square-and-multiply at full width
	function automatic longint unsigned power_mod(longint unsigned base,
			longint unsigned exponent, longint unsigned m);
		longint unsigned acc;
		longint unsigned b;
		acc = 64'd1 % m;
		b   = base % m;
		while (exponent != 0) begin
			if (exponent[0])
				acc = (acc * b) % m;
			b = (b * b) % m;
			exponent = exponent >> 1;
		end
		return acc;
	endfunction

	function automatic request_t make_request(logic [OP_W-1:0] op, logic [SECRET_W-1:0] sec,
			logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] c,
			logic [FIELD_W-1:0] t, logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] y);
		request_t req;
		req.operation       = op;
		req.secret          = sec;
		req.prove_key       = x;
		req.random_exponent = r;
		req.challenge       = c;
		req.commitment      = t;
		req.response        = s;
		req.verify_key      = y;
		return req;
	endfunction

	// expected outcome of one request under the current register values
	function automatic proof_result_t predict_proof_result(request_t req);
		proof_result_t   res;
		longint unsigned m;
		longint unsigned group_order;
		longint unsigned priv;
		longint unsigned g_pow_s;
		longint unsigned t_y_pow_c;
		m = effective_modulus();
		res.key_or_commitment = '0;
		res.private_key_out   = '0;
		res.response_out      = '0;
		res.accepted          = 1'b0;
		case (req.operation)
			OP_KEYGEN: begin
				priv = 64'(req.secret) % m;
				res.private_key_out   = priv[FIELD_W-1:0];
				res.key_or_commitment = FIELD_W'(power_mod(64'(mirror_gen), priv, m));
			end
			OP_PROVE: begin
				group_order = (mirror_prime >= 2) ? 64'(mirror_prime) - 1 : 64'd0;
				res.key_or_commitment = FIELD_W'(power_mod(64'(mirror_gen),
					64'(req.random_exponent), m));
				if (group_order != 0)
					res.response_out = FIELD_W'((64'(req.random_exponent)
						+ 64'(req.challenge) * 64'(req.prove_key)) % group_order);
			end
			OP_VERIFY: begin
				g_pow_s   = power_mod(64'(mirror_gen), 64'(req.response), m);
				t_y_pow_c = ((64'(req.commitment) % m)
					* power_mod(64'(req.verify_key), 64'(req.challenge), m)) % m;
				res.accepted = (g_pow_s == t_y_pow_c);
			end
			default: ;
		endcase
		return res;
	endfunction

	// verify request carrying an honest proof for key x, nonce r and challenge c
	function automatic request_t honest_verify(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] r,
			logic [FIELD_W-1:0] c);
		proof_result_t made;
		made = predict_proof_result(make_request(OP_PROVE, '0, x, r, c, '0, '0, '0));
		return make_request(OP_VERIFY, SECRET_W'($urandom), x, r, c, made.key_or_commitment,
			made.response_out,
			FIELD_W'(power_mod(64'(mirror_gen), 64'(x), effective_modulus())));
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		$display("error: %s", msg);
	endtask

	// send one request, with a random hold-off before it while idle_on is set
	task automatic send_request(request_t req);
		int gap;
		bit wait_idle;
		gap       = idle_on ? $urandom_range(0, 17) : 0;
		wait_idle = idle_on && ($urandom_range(0, 1) == 1);
		if (gap > 0 || wait_idle) begin
			start <= 1'b0;
			if (wait_idle) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		operation       <= req.operation;
		secret          <= req.secret;
		prove_key       <= req.prove_key;
		random_exponent <= req.random_exponent;
		challenge       <= req.challenge;
		commitment      <= req.commitment;
		response        <= req.response;
		verify_key      <= req.verify_key;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_proof_result(req));
	endtask

	// wait for every outstanding result, then idle for extra_cycles clocks
	task automatic drain_results(int extra_cycles);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	// apb write: setup cycle then access cycle, upper data bits random
	task automatic write_register(logic [ADDR_W-1:0] addr, logic [FIELD_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {FIELD_W'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_PRIME)
			mirror_prime = value;
		else
			mirror_gen = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] g);
		drain_results(IDLE_CYCLES);
		write_register(ADDR_PRIME, p);
		write_register(ADDR_GEN, g);
	endtask

	// reset values: field extremes and every operation
	task automatic test_reset_defaults();
		send_request(make_request(OP_KEYGEN, '0, '0, '0, '0, '0, '0, '0));
		send_request(make_request(OP_KEYGEN, '1, '0, '0, '0, '0, '0, '0));
		// secret a multiple of the modulus gives a zero exponent
		send_request(make_request(OP_KEYGEN, SECRET_W'(int'(P_RESET) * 5),
			'0, '0, '0, '0, '0, '0));
		send_request(make_request(OP_PROVE, '0, '0, '0, '0, '0, '0, '0));
		// nonce above p-1 is used unreduced as the exponent
		send_request(make_request(OP_PROVE, '1, 16'd65534, 16'd65534, '1, '1, '1, '1));
		send_request(honest_verify(16'd1234, 16'd777, 16'd4321));
		send_request(make_request(OP_VERIFY, '0, '0, '0, '0, '0, '0, '0));
		// commitment above p reduces to one, zero exponents on both sides
		send_request(make_request(OP_VERIFY, '0, '0, '0, '0, P_RESET + 16'd1, '0, '1));
		send_request(make_request(OP_VERIFY, '1, 16'd65534, 16'd65534, '1, '1, '1, '1));
		send_request(make_request(OP_UNUSED, '1, 16'd65534, 16'd65534, '1, '1, '1, '1));
	endtask

	// largest modulus with a generator just below it, then a generator far above the modulus, then a generator of one
	task automatic test_generator_extremes();
		configure(16'd65535, 16'd65534);
		send_request(make_request(OP_KEYGEN, '1, '0, '0, '0, '0, '0, '0));
		send_request(make_request(OP_PROVE, '0, 16'd65534, 16'd65534, '1, '0, '0, '0));
		send_request(honest_verify(16'd65534, 16'd65534, 16'd65535));
		configure(16'd3, 16'd65534);
		send_request(make_request(OP_KEYGEN, SECRET_W'(5), '0, '0, '0, '0, '0, '0));
		send_request(make_request(OP_PROVE, '0, 16'd7, 16'd65534, 16'd3, '0, '0, '0));
		send_request(honest_verify(16'd2, 16'd9, 16'd40000));
		configure(16'd65521, 16'd1);
		send_request(honest_verify(16'd300, 16'd65000, 16'd12));
	endtask

	// moduli zero, one and two: residues collapse and the response is zero
	task automatic test_degenerate_modulus();
		configure(16'd0, 16'd5);
		send_request(make_request(OP_KEYGEN, SECRET_W'(12345), '0, '0, '0, '0, '0, '0));
		send_request(make_request(OP_PROVE, '0, 16'd100, 16'd200, 16'd300, '0, '0, '0));
		send_request(make_request(OP_VERIFY, '0, '0, '0, 16'd3, 16'd8, 16'd1, 16'd4));
		configure(16'd1, 16'd2);
		send_request(make_request(OP_KEYGEN, '1, '0, '0, '0, '0, '0, '0));
		send_request(honest_verify(16'd11, 16'd22, 16'd33));
		configure(16'd2, 16'd3);
		send_request(make_request(OP_PROVE, '0, 16'd65534, 16'd65534, '1, '0, '0, '0));
	endtask

	// random traffic over several register settings, mixing honest and broken proofs with random requests
	task automatic test_random_traffic();
		request_t          req;
		int unsigned       kind;
		int unsigned       flip_bit;
		logic [FIELD_W-1:0] p;
		logic [FIELD_W-1:0] g;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       begin p = 16'd65521; g = 16'd17; end
				1:       begin p = 16'd3329;  g = FIELD_W'($urandom_range(1, 65534)); end
				2:       begin p = 16'd257;   g = 16'd3; end
				3:       begin p = 16'd3;     g = 16'd2; end
				4:       begin p = 16'd65535; g = FIELD_W'($urandom_range(1, 65534)); end
				default: begin p = 16'd12289; g = FIELD_W'($urandom_range(2, 100)); end
			endcase
			configure(p, g);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				req = make_request(OP_W'($urandom_range(0, 2)), SECRET_W'($urandom),
					FIELD_W'($urandom_range(0, 65534)), FIELD_W'($urandom_range(0, 65534)),
					FIELD_W'($urandom_range(0, 65535)), FIELD_W'($urandom_range(0, 65535)),
					FIELD_W'($urandom_range(0, 65535)), FIELD_W'($urandom_range(0, 65535)));
				kind = $urandom_range(0, 99);
				if (kind < 40) begin
					req = honest_verify(req.prove_key, req.random_exponent, req.challenge);
					flip_bit = $urandom_range(0, FIELD_W - 1);
					// a broken proof: one bit of one field flipped
					if (kind < 10) begin
						case ($urandom_range(0, 3))
							0: req.commitment = req.commitment ^ (16'h0001 << flip_bit);
							1: req.response   = req.response ^ (16'h0001 << flip_bit);
							2: req.verify_key = req.verify_key ^ (16'h0001 << flip_bit);
							default: req.challenge = req.challenge ^ (16'h0001 << flip_bit);
						endcase
					end else if (kind < 16) begin
						// same residue written above the modulus
						if (int'(req.commitment) + int'(mirror_prime) <= 65535)
							req.commitment = req.commitment + mirror_prime;
					end
				end else if (kind < 58) begin
					req.operation = OP_KEYGEN;
				end else if (kind < 80) begin
					req.operation = OP_PROVE;
				end else if (kind < 95) begin
					req.operation = OP_VERIFY;
				end else begin
					req.operation = OP_UNUSED;
				end
				send_request(req);
			end
		end
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		proof_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				want = pending_results.pop_front();
				if (key_or_commitment !== want.key_or_commitment)
					report_mismatch($sformatf("result %0d key_or_commitment %h, expected %h",
						results_seen, key_or_commitment, want.key_or_commitment));
				if (private_key_out !== want.private_key_out)
					report_mismatch($sformatf("result %0d private_key_out %h, expected %h",
						results_seen, private_key_out, want.private_key_out));
				if (response_out !== want.response_out)
					report_mismatch($sformatf("result %0d response_out %h, expected %h",
						results_seen, response_out, want.response_out));
				if (accepted !== want.accepted)
					report_mismatch($sformatf("result %0d accepted %b, expected %b",
						results_seen, accepted, want.accepted));
			end
			results_seen++;
		end
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("schnorr_identification_engine: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_generator_extremes();
		test_degenerate_modulus();
		test_random_traffic();
		drain_results(SETTLE_CYCLES);
		if (error_count == 0)
			$display("schnorr_identification_engine: match");
		else
			$display("schnorr_identification_engine: mismatch");
		$finish;
	end

endmodule

/* schnorr_identification_engine.f */
+incdir+src
src/sie_pkg.sv
src/sie_modmul.sv
src/schnorr_identification_engine.sv
verif/schnorr_identification_engine_test.sv
